@@ rtl/psq_pkg.sv @@
// psq_pkg: shared types and widths for the skewed quadrilateral hit test
// no dependencies
`default_nettype none
package psq_pkg;
   localparam int unsigned CoordWidth = 32;
   localparam int unsigned SizeWidth = 31;

   typedef struct packed {
      logic signed [CoordWidth-1:0] center_x;
      logic signed [CoordWidth-1:0] center_y;
      logic [SizeWidth-1:0] shape_width;
      logic [SizeWidth-1:0] shape_height;
      logic signed [CoordWidth-1:0] top_skew_x;
      logic signed [CoordWidth-1:0] right_skew_y;
      logic signed [CoordWidth-1:0] point_x;
      logic signed [CoordWidth-1:0] point_y;
   } req_type;

   typedef struct packed {
      logic hit;
      logic bad_shape;
   } rsp_type;

   // one edge check: d, num, delta, den at doubled scale
   typedef struct packed {
      logic signed [35:0] d;
      logic signed [33:0] num;
      logic signed [35:0] delta;
      logic [32:0] den;
      logic above;
   } edge_type;
endpackage
`default_nettype wire

@@ rtl/psq_edge.sv @@
// psq_edge: pipelined inclusive test of one edge line against the point
// depends on psq_pkg
`default_nettype none
module psq_edge (
   input  wire logic clock,
   input  wire logic reset,
   input  wire psq_pkg::edge_type in_edge,
   output logic out_ok
);
   // operand slices for the split products
   logic signed [17:0] num_hi, num_lo, den_hi, den_lo;
   logic signed [18:0] dlt_hi, dlt_lo, d_hi, d_lo;
   // stage a: partial products of num * delta and d * den
   logic signed [36:0] pn_in [4];
   logic signed [36:0] pn_ff [4];
   logic signed [36:0] pd_in [4];
   logic signed [36:0] pd_ff [4];
   logic [32:0] den_a_ff;
   logic above_a_ff;
   // stage b: full products
   logic signed [69:0] n_in, n_b_ff;
   logic signed [70:0] m_in, m_b_ff;
   logic [32:0] den_b_ff;
   logic above_b_ff;
   // stage c: d product moved by one den for the sign case
   logic signed [70:0] adj, m_c_in, m_c_ff;
   logic signed [69:0] n_c_ff;
   logic neg, neg_c_ff, above_c_ff;
   logic ok_in;

   // slice operands, signed high part (unsigned for den) and unsigned low part
   always_comb begin
      num_hi = 18'($signed(in_edge.num[33:17]));
      num_lo = $signed({1'b0, in_edge.num[16:0]});
      dlt_hi = 19'($signed(in_edge.delta[35:18]));
      dlt_lo = $signed({1'b0, in_edge.delta[17:0]});
      d_hi = 19'($signed(in_edge.d[35:18]));
      d_lo = $signed({1'b0, in_edge.d[17:0]});
      den_hi = $signed({2'b0, in_edge.den[32:17]});
      den_lo = $signed({1'b0, in_edge.den[16:0]});
      pn_in[0] = num_lo * dlt_lo;
      pn_in[1] = num_lo * dlt_hi;
      pn_in[2] = num_hi * dlt_lo;
      pn_in[3] = num_hi * dlt_hi;
      pd_in[0] = d_lo * den_lo;
      pd_in[1] = d_lo * den_hi;
      pd_in[2] = d_hi * den_lo;
      pd_in[3] = d_hi * den_hi;
   end

   // sum the partial products
   always_comb begin
      n_in = 70'(pn_ff[0]) + (70'(pn_ff[1]) <<< 18) + (70'(pn_ff[2]) <<< 17)
           + (70'(pn_ff[3]) <<< 35);
      m_in = 71'(pd_ff[0]) + (71'(pd_ff[1]) <<< 17) + (71'(pd_ff[2]) <<< 18)
           + (71'(pd_ff[3]) <<< 35);
   end

   // (d + 1) * den or (d - 1) * den where the truncation needs it
   always_comb begin
      neg = n_b_ff < 0;
      if (above_b_ff && !neg)
         adj = $signed({38'd0, den_b_ff});
      else if (!above_b_ff && neg)
         adj = -$signed({38'd0, den_b_ff});
      else
         adj = '0;
      m_c_in = m_b_ff + adj;
   end

   // compare against the exact numerator
   always_comb begin
      if (above_c_ff)
         ok_in = neg_c_ff ? (m_c_ff >= 71'(n_c_ff)) : (m_c_ff > 71'(n_c_ff));
      else
         ok_in = neg_c_ff ? (m_c_ff < 71'(n_c_ff)) : (m_c_ff <= 71'(n_c_ff));
   end

   always_ff @(posedge clock) begin
      pn_ff <= pn_in;
      pd_ff <= pd_in;
      den_a_ff <= in_edge.den;
      above_a_ff <= in_edge.above;
      n_b_ff <= n_in;
      m_b_ff <= m_in;
      den_b_ff <= den_a_ff;
      above_b_ff <= above_a_ff;
      m_c_ff <= m_c_in;
      n_c_ff <= n_b_ff;
      neg_c_ff <= neg;
      above_c_ff <= above_b_ff;
      if (reset)
         out_ok <= 1'b0;
      else
         out_ok <= ok_in;
   end
endmodule
`default_nettype wire

@@ rtl/point_in_skewed_quad_test_core.sv @@
// point_in_skewed_quad_test_core: streaming point in skewed quad test
// depends on psq_pkg, psq_edge
//
// channel | direction | handshake       | payload
// req     | in        | req_start/busy  | psq_pkg::req_type
// rsp     | out       | rsp_strobe      | psq_pkg::rsp_type
//
// one beat per cycle; results come out in the order of their beats
// stages: corner setup, partial products, product sums, sign adjust, compare
// busy is always low; the receiver cannot stall, so nothing waits
// synchronous reset clears the valid bits and the edge results only
`default_nettype none
module point_in_skewed_quad_test_core (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_start,
   output logic req_busy,
   input  wire psq_pkg::req_type req_data,
   output logic rsp_strobe,
   output psq_pkg::rsp_type rsp_data
);
   psq_pkg::edge_type e_in [4];
   psq_pkg::edge_type e_ff [4];
   logic [3:0] ok;
   logic [4:0] valid_ff;
   logic [4:0] bad_ff;
   logic signed [35:0] cx, cy, ts, rs, px, py, w, h;
   logic signed [35:0] blx, bly, brx, bry, trx, try_y, tlx, tly;

   assign req_busy = 1'b0;

   // corners at doubled scale
   always_comb begin
      cx = 36'(req_data.center_x) <<< 1;
      cy = 36'(req_data.center_y) <<< 1;
      ts = 36'(req_data.top_skew_x) <<< 1;
      rs = 36'(req_data.right_skew_y) <<< 1;
      px = 36'(req_data.point_x) <<< 1;
      py = 36'(req_data.point_y) <<< 1;
      w = $signed({5'd0, req_data.shape_width});
      h = $signed({5'd0, req_data.shape_height});
      blx = cx - w; bly = cy - h;
      brx = cx + w; bry = cy - h + rs;
      trx = cx + w + ts; try_y = cy + h + rs;
      tlx = cx - w + ts; tly = cy + h;
      e_in[0] = '{d: py - bly, num: 34'(rs), delta: px - blx,
                  den: {w[31:0], 1'b0}, above: 1'b1};
      e_in[1] = '{d: px - brx, num: 34'(ts), delta: py - bry,
                  den: {h[31:0], 1'b0}, above: 1'b0};
      e_in[2] = '{d: py - try_y, num: 34'(rs), delta: px - trx,
                  den: {w[31:0], 1'b0}, above: 1'b0};
      e_in[3] = '{d: px - tlx, num: 34'(ts), delta: py - tly,
                  den: {h[31:0], 1'b0}, above: 1'b1};
   end

   // setup register stage
   always_ff @(posedge clock) begin
      e_ff <= e_in;
      bad_ff <= {bad_ff[3:0],
                 (req_data.shape_width == '0) || (req_data.shape_height == '0)};
      if (reset)
         valid_ff <= '0;
      else
         valid_ff <= {valid_ff[3:0], req_start};
   end

   for (genvar g = 0; g < 4; g++) begin : g_edge
      psq_edge u_edge (
         .clock(clock), .reset(reset),
         .in_edge(e_ff[g]), .out_ok(ok[g]));
   end

   assign rsp_strobe = valid_ff[4];
   assign rsp_data.bad_shape = bad_ff[4];
   assign rsp_data.hit = (&ok) & ~bad_ff[4];

   a_bad_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.bad_shape |-> !rsp_data.hit) else $error("hit on bad shape");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_start |-> ##5 rsp_strobe) else $error("result lost");
   a_never_busy: assert property (@(posedge clock) !req_busy) else $error("busy");
endmodule
`default_nettype wire
